>>> src/smi_pkg.sv
package smi_pkg;

   localparam int ADDR_W = 10;
   localparam int DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } command_type;

   typedef struct packed {
      logic              line_out;
      logic              line_drive;
      logic              clock_pulse;
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] read_data;
   } result_type;

endpackage

>>> src/smi_frame_core.sv
module smi_frame_core #(
   parameter int PREAMBLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [1:0]                    command,
   input  logic [smi_pkg::ADDR_W-1:0]    reg_address,
   input  logic [smi_pkg::DATA_W-1:0]    write_data,
   input  logic                          line_in,
   output smi_pkg::result_type           result
);

   localparam int PHASE_W = $clog2(PREAMBLE_BITS + 32);
   localparam logic [PHASE_W-1:0] PH_START0 = PHASE_W'(PREAMBLE_BITS);
   localparam logic [PHASE_W-1:0] PH_START1 = PHASE_W'(PREAMBLE_BITS + 1);
   localparam logic [PHASE_W-1:0] PH_OP0    = PHASE_W'(PREAMBLE_BITS + 2);
   localparam logic [PHASE_W-1:0] PH_OP1    = PHASE_W'(PREAMBLE_BITS + 3);
   localparam logic [PHASE_W-1:0] PH_TAIL   = PHASE_W'(PREAMBLE_BITS + 14);
   localparam logic [PHASE_W-1:0] Q_ONE     = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] Q_RD_LAST = PHASE_W'(smi_pkg::DATA_W);
   localparam logic [PHASE_W-1:0] Q_WR_LAST = PHASE_W'(smi_pkg::DATA_W + 1);

   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic                       busy_ff, busy_in;
   logic                       is_read_ff, is_read_in;
   logic [smi_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [smi_pkg::DATA_W-1:0] data_ff, data_in;

   logic                       start, active, rd;
   logic [PHASE_W-1:0]         p, q;
   logic [smi_pkg::ADDR_W-1:0] addr_cur;
   logic [smi_pkg::DATA_W-1:0] data_cur;
   logic                       done;

   always_comb begin
      start    = !busy_ff && (command == smi_pkg::CMD_READ || command == smi_pkg::CMD_WRITE);
      active   = busy_ff || start;
      rd       = busy_ff ? is_read_ff : (command == smi_pkg::CMD_READ);
      addr_cur = busy_ff ? addr_ff : reg_address;
      data_cur = busy_ff ? data_ff : (rd ? '0 : write_data);
      p        = busy_ff ? phase_ff : '0;
      q        = p - PH_TAIL;
      done     = 1'b0;
      addr_in  = addr_cur;
      data_in  = data_cur;

      result.line_out    = 1'b1;
      result.line_drive  = 1'b1;
      result.clock_pulse = active;
      result.busy        = active;
      result.done        = 1'b0;
      result.read_data   = '0;

      if (active) begin
         if (p < PH_START0) begin
            result.line_out = 1'b1;
         end else if (p == PH_START0) begin
            result.line_out = 1'b0;
         end else if (p == PH_START1) begin
            result.line_out = 1'b1;
         end else if (p == PH_OP0) begin
            result.line_out = rd;
         end else if (p == PH_OP1) begin
            result.line_out = !rd;
         end else if (p < PH_TAIL) begin
            result.line_out = addr_cur[smi_pkg::ADDR_W-1];
            addr_in = {addr_cur[smi_pkg::ADDR_W-2:0], 1'b0};
         end else if (rd) begin
            result.line_out   = 1'b0;
            result.line_drive = 1'b0;
            if (q != '0) begin
               data_in = {data_cur[smi_pkg::DATA_W-2:0], line_in};
               if (q >= Q_RD_LAST) begin
                  done             = 1'b1;
                  result.read_data = data_in;
               end
            end
         end else begin
            if (q == '0) begin
               result.line_out = 1'b1;
            end else if (q == Q_ONE) begin
               result.line_out = 1'b0;
            end else begin
               result.line_out = data_cur[smi_pkg::DATA_W-1];
               data_in = {data_cur[smi_pkg::DATA_W-2:0], 1'b0};
               if (q >= Q_WR_LAST) begin
                  done = 1'b1;
               end
            end
         end
      end
      result.done = done;

      busy_in    = active && !done;
      phase_in   = (active && !done) ? p + Q_ONE : '0;
      is_read_in = active ? rd : is_read_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         busy_ff    <= 1'b0;
         is_read_ff <= 1'b0;
         addr_ff    <= '0;
         data_ff    <= '0;
      end else if (step && active) begin
         phase_ff   <= phase_in;
         busy_ff    <= busy_in;
         is_read_ff <= is_read_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
      end
   end

endmodule

>>> src/smi_management_frame_master.sv
// Management-bus frame master, one beat per bit period of the serial line.
// Request channel: req_valid/req_stall carry command, register address, write
// word and the sampled data-line level for one bit period. An idle master
// starts a read or write frame on a read or write command; commands are
// ignored while a frame is running.
// Response channel: rsp_valid/rsp_stall carry, for each request beat, the line
// level, drive enable, clock pulse, busy and done flags and the read word,
// which is non-zero only on the final beat of a read frame.
// From request acceptance to the response beat each beat passes one input
// register and one result register. Throughput is one beat per cycle while
// the receiver does not stall; the frame state advances as each beat moves
// from the input register to the result register.
// A write frame spans PREAMBLE_BITS + 32 beats, a read frame PREAMBLE_BITS + 31.
// Reset is synchronous and returns the master to idle with both registers
// empty. When the receiver stalls, the result register holds its beat, the
// input register fills behind it and req_stall then rises; nothing is lost.
module smi_management_frame_master #(
   parameter int PREAMBLE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [smi_pkg::ADDR_W-1:0] req_reg_address,
   input  logic [smi_pkg::DATA_W-1:0] req_write_data,
   input  logic                       req_line_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_line_out,
   output logic                       rsp_line_drive,
   output logic                       rsp_clock_pulse,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic [smi_pkg::DATA_W-1:0] rsp_read_data
);

   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 cmd_ff;
   logic [smi_pkg::ADDR_W-1:0] addr_ff;
   logic [smi_pkg::DATA_W-1:0] wdata_ff;
   logic                       lin_ff;
   logic                       out_valid_ff, out_valid_in;
   smi_pkg::result_type        res_ff, res_next;
   logic                       advance, accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   smi_frame_core #(
      .PREAMBLE_BITS(PREAMBLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .command    (cmd_ff),
      .reg_address(addr_ff),
      .write_data (wdata_ff),
      .line_in    (lin_ff),
      .result     (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_reg_address;
         wdata_ff <= req_write_data;
         lin_ff   <= req_line_in;
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_out    = res_ff.line_out;
   assign rsp_line_drive  = res_ff.line_drive;
   assign rsp_clock_pulse = res_ff.clock_pulse;
   assign rsp_busy_res    = res_ff.busy;
   assign rsp_done_res    = res_ff.done;
   assign rsp_read_data   = res_ff.read_data;

endmodule

>>> tb/smi_management_frame_master_tb.sv
module smi_management_frame_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PREAMBLE = 32;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int FIRST_CHUNK_BEATS = 500;
   localparam int TOTAL_BEATS = 1100;
   localparam int QUIET_TAIL_BEATS = 200;

   typedef logic [smi_pkg::ADDR_W-1:0] address_type;
   typedef logic [smi_pkg::DATA_W-1:0] word_type;

   typedef struct {
      logic [1:0]  command;
      address_type reg_address;
      word_type    write_data;
      logic        line_in;
   } bit_period_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = smi_pkg::CMD_NONE;
   address_type req_reg_address = '0;
   word_type    req_write_data = '0;
   logic        req_line_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_line_out;
   logic        rsp_line_drive;
   logic        rsp_clock_pulse;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   word_type    rsp_read_data;

   bit_period_type      pending_beats[$];
   smi_pkg::result_type expected_periods[$];

   logic [6:0]  frame_phase = '0;
   logic        frame_active = 1'b0;
   logic        frame_read = 1'b0;
   address_type address_left = '0;
   word_type    word_bits = '0;

   int  failures = 0;
   int  frame_beats = 0;
   int  results_seen = 0;
   bit  quiet_tail = 1'b0;
   bit  long_hold = 1'b0;
   bit  long_hold_done = 1'b0;
   int  long_hold_count = 0;

   smi_management_frame_master #(
      .PREAMBLE_BITS(PREAMBLE)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_reg_address(req_reg_address),
      .req_write_data (req_write_data),
      .req_line_in    (req_line_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_out   (rsp_line_out),
      .rsp_line_drive (rsp_line_drive),
      .rsp_clock_pulse(rsp_clock_pulse),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data)
   );

   always #5 clock = ~clock;

   function automatic smi_pkg::result_type predict_period(bit_period_type b);
      smi_pkg::result_type r;
      int unsigned q;
      r = '0;
      r.line_out = 1'b1;
      r.line_drive = 1'b1;
      if (!frame_active) begin
         if (b.command != smi_pkg::CMD_READ && b.command != smi_pkg::CMD_WRITE) begin
            return r;
         end
         frame_active = 1'b1;
         frame_read = (b.command == smi_pkg::CMD_READ);
         address_left = b.reg_address;
         word_bits = frame_read ? '0 : b.write_data;
         frame_phase = '0;
      end
      r.clock_pulse = 1'b1;
      r.busy = 1'b1;
      if (frame_phase < PREAMBLE) begin
         r.line_out = 1'b1;
      end else if (frame_phase == PREAMBLE) begin
         r.line_out = 1'b0;
      end else if (frame_phase == PREAMBLE + 1) begin
         r.line_out = 1'b1;
      end else if (frame_phase == PREAMBLE + 2) begin
         r.line_out = frame_read;
      end else if (frame_phase == PREAMBLE + 3) begin
         r.line_out = !frame_read;
      end else if (frame_phase < PREAMBLE + 14) begin
         r.line_out = address_left[smi_pkg::ADDR_W-1];
         address_left = address_left << 1;
      end else begin
         q = frame_phase - (PREAMBLE + 14);
         if (frame_read) begin
            r.line_out = 1'b0;
            r.line_drive = 1'b0;
            if (q != 0) begin
               word_bits = {word_bits[smi_pkg::DATA_W-2:0], b.line_in};
               if (q >= 16) begin
                  r.done = 1'b1;
                  r.read_data = word_bits;
               end
            end
         end else if (q == 0) begin
            r.line_out = 1'b1;
         end else if (q == 1) begin
            r.line_out = 1'b0;
         end else begin
            r.line_out = word_bits[smi_pkg::DATA_W-1];
            word_bits = word_bits << 1;
            if (q >= 17) begin
               r.done = 1'b1;
            end
         end
      end
      if (r.done) begin
         frame_active = 1'b0;
         frame_phase = '0;
      end else begin
         frame_phase = frame_phase + 7'd1;
      end
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic add_idle_beat(logic [1:0] cmd);
      bit_period_type b;
      b.command = cmd;
      b.reg_address = address_type'($urandom_range(0, 1023));
      b.write_data = word_type'($urandom_range(0, 65535));
      b.line_in = 1'($urandom_range(0, 1));
      pending_beats.push_back(b);
   endtask

   task automatic add_frame(logic [1:0] cmd, address_type addr,
                            word_type wdata, word_type read_word,
                            bit noisy);
      bit_period_type b;
      int len;
      len = (cmd == smi_pkg::CMD_READ) ? PREAMBLE + 31 : PREAMBLE + 32;
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            b.command = cmd;
            b.reg_address = addr;
            b.write_data = wdata;
         end else if (noisy) begin
            b.command = 2'($urandom_range(0, 3));
            b.reg_address = address_type'($urandom_range(0, 1023));
            b.write_data = word_type'($urandom_range(0, 65535));
         end else begin
            b.command = smi_pkg::CMD_NONE;
            b.reg_address = '0;
            b.write_data = '0;
         end
         if (cmd == smi_pkg::CMD_READ && i >= PREAMBLE + 15) begin
            b.line_in = read_word[smi_pkg::DATA_W-1-(i-PREAMBLE-15)];
         end else begin
            b.line_in = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
         end
         pending_beats.push_back(b);
      end
      frame_beats += len;
   endtask

   task automatic add_random_traffic(int upto);
      logic [1:0] cmd;
      while (frame_beats < upto) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               add_idle_beat($urandom_range(0, 1) ? smi_pkg::CMD_NONE : CMD_UNUSED);
            end
         end else begin
            cmd = $urandom_range(0, 1) ? smi_pkg::CMD_READ : smi_pkg::CMD_WRITE;
            add_frame(cmd, address_type'($urandom_range(0, 1023)),
                      word_type'($urandom_range(0, 65535)),
                      word_type'($urandom_range(0, 65535)), $urandom_range(0, 4) != 0);
         end
      end
   endtask

   // Driver: offers the queued bit periods and predicts each accepted beat.
   always @(posedge clock) begin
      bit_period_type driven_beat;
      int send_gap;
      int send_odds;
      int mode_count;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         send_odds = 4;
         mode_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_periods.push_back(predict_period(driven_beat));
            mode_count++;
            if (mode_count == 128) begin
               mode_count = 0;
               case ($urandom_range(0, 2))
                  0: send_odds = 0;
                  1: send_odds = 3;
                  default: send_odds = 12;
               endcase
            end
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet_tail && send_odds != 0 &&
                         $urandom_range(0, send_odds) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               driven_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_command <= driven_beat.command;
               req_reg_address <= driven_beat.reg_address;
               req_write_data <= driven_beat.write_data;
               req_line_in <= driven_beat.line_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted response beat with the oldest prediction.
   always @(posedge clock) begin
      smi_pkg::result_type want;
      int stall_left;
      int stall_odds;
      int mode_count;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         stall_odds = 5;
         mode_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_periods.size() == 0) begin
               $error("Response beat arrived with no prediction waiting.");
               failures++;
            end else begin
               want = expected_periods.pop_front();
               check_field("line_out", want.line_out, rsp_line_out);
               check_field("line_drive", want.line_drive, rsp_line_drive);
               check_field("clock_pulse", want.clock_pulse, rsp_clock_pulse);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("done_res", want.done, rsp_done_res);
               check_field("read_data", want.read_data, rsp_read_data);
            end
            results_seen <= results_seen + 1;
            mode_count++;
            if (mode_count == 100) begin
               mode_count = 0;
               case ($urandom_range(0, 2))
                  0: stall_odds = 0;
                  1: stall_odds = 3;
                  default: stall_odds = 10;
               endcase
            end
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && stall_odds != 0 &&
                      $urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One long hold-off on the response side so that the master backs up and
   // stalls its request channel while the sender keeps offering beats.
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         long_hold_done <= 1'b0;
         long_hold_count <= 0;
      end else if (long_hold) begin
         if (long_hold_count == LONG_HOLD_CYCLES - 1) begin
            long_hold <= 1'b0;
         end
         long_hold_count <= long_hold_count + 1;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
         long_hold <= 1'b1;
         long_hold_done <= 1'b1;
         long_hold_count <= 0;
      end
   end

   initial begin
      add_idle_beat(smi_pkg::CMD_NONE);
      add_idle_beat(CMD_UNUSED);
      add_frame(smi_pkg::CMD_WRITE, '0, 16'hFFFF, '0, 1'b0);
      add_frame(smi_pkg::CMD_WRITE, 10'h3FF, 16'h0000, '0, 1'b1);
      add_frame(smi_pkg::CMD_READ, 10'h3FF, '0, 16'hFFFF, 1'b1);
      add_frame(smi_pkg::CMD_READ, 10'h000, '0, 16'h0000, 1'b0);
      add_idle_beat(CMD_UNUSED);
      add_frame(smi_pkg::CMD_READ, 10'h2A5, '0, 16'hA55A, 1'b1);
      add_frame(smi_pkg::CMD_WRITE, 10'h15A, 16'h5AA5, '0, 1'b1);
      add_random_traffic(FIRST_CHUNK_BEATS);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The sender pauses here until every predicted beat has come back.
      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_periods.size() != 0) @(posedge clock);

      add_random_traffic(TOTAL_BEATS);
      while (pending_beats.size() > QUIET_TAIL_BEATS) @(posedge clock);
      quiet_tail <= 1'b1;

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_periods.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
src/smi_pkg.sv
src/smi_frame_core.sv
src/smi_management_frame_master.sv
tb/smi_management_frame_master_tb.sv
